FILE: hw/rtl/cfvg_pkg.sv
// Shared constants, types and the arctangent table of the circle fan vertex generator.
package cfvg_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int PH_W         = ANGLE_BITS + 1;
	localparam int SEG_W        = 6;
	localparam int MAX_SEGMENTS = 62;
	localparam int RAD_W        = 16;
	localparam int POS_W        = 17;
	localparam int POS_MAX      = 65535;
	localparam int IN_W         = 24;
	localparam int OUT_W        = 40;
	localparam int TURN_W       = 32;
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int XY_W         = 34;
	localparam int Z_W          = 33;
	localparam int ATAN_W       = 30;
	localparam int V_W          = 32;
	localparam int FRAC_BITS    = 30;
	localparam int CORDIC_GAIN  = 652032874;
	localparam int DIV_STEPS    = PH_W;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT,
		ST_STEP,
		ST_CORD,
		ST_SCL_X,
		ST_SCL_Y
	} state_t;

	// atan(2^-k) in units of 2^-32 of a full turn.
	function automatic logic [ATAN_W-1:0] atan_turn(input logic [STEP_W-1:0] k);
		logic [ATAN_W-1:0] a;
		case (k)
			5'd0:    a = 30'd536870912;
			5'd1:    a = 30'd316933406;
			5'd2:    a = 30'd167458907;
			5'd3:    a = 30'd85004756;
			5'd4:    a = 30'd42667331;
			5'd5:    a = 30'd21354465;
			5'd6:    a = 30'd10679838;
			5'd7:    a = 30'd5340245;
			5'd8:    a = 30'd2670163;
			5'd9:    a = 30'd1335087;
			5'd10:   a = 30'd667544;
			5'd11:   a = 30'd333772;
			5'd12:   a = 30'd166886;
			5'd13:   a = 30'd83443;
			5'd14:   a = 30'd41722;
			5'd15:   a = 30'd20861;
			5'd16:   a = 30'd10430;
			5'd17:   a = 30'd5215;
			5'd18:   a = 30'd2608;
			5'd19:   a = 30'd1304;
			5'd20:   a = 30'd652;
			5'd21:   a = 30'd326;
			5'd22:   a = 30'd163;
			5'd23:   a = 30'd81;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

FILE: hw/rtl/cfvg_div.sv
// Bit-serial restoring divider that splits a full turn by the segment count.
module cfvg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cfvg_pkg::SEG_W-1:0]  divisor,
	output logic                        done,
	output logic [cfvg_pkg::PH_W-1:0]   quotient,
	output logic [cfvg_pkg::SEG_W-1:0]  remainder
);

	logic [cfvg_pkg::SEG_W-1:0]     div_q;
	logic [cfvg_pkg::SEG_W-1:0]     rem_q;
	logic [cfvg_pkg::PH_W-1:0]      quo_q;
	logic [cfvg_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           run_q;
	logic                           done_q;
	logic [cfvg_pkg::SEG_W:0]       rem_sh;
	logic [cfvg_pkg::SEG_W:0]       rem_sub;
	logic                           ge;

	assign rem_sh  = {rem_q, quo_q[cfvg_pkg::PH_W-1]};
	assign ge      = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == cfvg_pkg::DIV_CNT_W'(cfvg_pkg::DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out of the top of quo_q while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= cfvg_pkg::PH_W'(1) << cfvg_pkg::ANGLE_BITS;
		end else if (run_q) begin
			rem_q <= ge ? rem_sub[cfvg_pkg::SEG_W-1:0] : rem_sh[cfvg_pkg::SEG_W-1:0];
			quo_q <= {quo_q[cfvg_pkg::PH_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: hw/rtl/cfvg_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a turn angle in Q2.30.
module cfvg_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [cfvg_pkg::TURN_W-1:0]       turn,
	output logic                              done,
	output logic signed [cfvg_pkg::V_W-1:0]   cos_v,
	output logic signed [cfvg_pkg::V_W-1:0]   sin_v
);

	logic signed [cfvg_pkg::XY_W-1:0] x_q;
	logic signed [cfvg_pkg::XY_W-1:0] y_q;
	logic signed [cfvg_pkg::Z_W-1:0]  z_q;
	logic [1:0]                       quad_q;
	logic [cfvg_pkg::STEP_W-1:0]      k_q;
	logic                             run_q;
	logic                             done_q;
	logic signed [cfvg_pkg::XY_W-1:0] dx;
	logic signed [cfvg_pkg::XY_W-1:0] dy;
	logic signed [cfvg_pkg::Z_W-1:0]  da;
	logic signed [cfvg_pkg::XY_W-1:0] cx;
	logic signed [cfvg_pkg::XY_W-1:0] cy;

	assign dx = y_q >>> k_q;
	assign dy = x_q >>> k_q;
	assign da = $signed(cfvg_pkg::Z_W'(cfvg_pkg::atan_turn(k_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				k_q   <= '0;
			end else if (run_q) begin
				k_q <= k_q + 1'b1;
				if (k_q == cfvg_pkg::STEP_W'(cfvg_pkg::CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The angle within the quadrant is rotated here; the quadrant itself is applied at the output.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= cfvg_pkg::XY_W'(cfvg_pkg::CORDIC_GAIN);
			y_q    <= '0;
			z_q    <= $signed(cfvg_pkg::Z_W'(turn[cfvg_pkg::TURN_W-3:0]));
			quad_q <= turn[cfvg_pkg::TURN_W-1:cfvg_pkg::TURN_W-2];
		end else if (run_q) begin
			if (!z_q[cfvg_pkg::Z_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - da;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + da;
			end
		end
	end

	always_comb begin
		case (quad_q)
			2'd1: begin
				cx = -y_q;
				cy = x_q;
			end
			2'd2: begin
				cx = -x_q;
				cy = -y_q;
			end
			2'd3: begin
				cx = y_q;
				cy = -x_q;
			end
			default: begin
				cx = x_q;
				cy = y_q;
			end
		endcase
	end

	assign done  = done_q;
	assign cos_v = cx[cfvg_pkg::V_W-1:0];
	assign sin_v = cy[cfvg_pkg::V_W-1:0];

endmodule

FILE: hw/rtl/cfvg_scale.sv
// Two-stage radius multiplier with round-half-up and clamping to the coordinate range.
module cfvg_scale (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [cfvg_pkg::RAD_W-1:0]        radius,
	input  logic signed [cfvg_pkg::V_W-1:0]   value,
	output logic                              done,
	output logic signed [cfvg_pkg::POS_W-1:0] result
);

	localparam int PROD_W = cfvg_pkg::RAD_W + 1 + cfvg_pkg::V_W;
	localparam int P_W    = PROD_W - cfvg_pkg::FRAC_BITS;
	localparam logic signed [P_W-1:0] P_HI = P_W'(cfvg_pkg::POS_MAX);
	localparam logic signed [P_W-1:0] P_LO = -P_HI;

	logic signed [cfvg_pkg::RAD_W:0]  rad_s;
	logic signed [PROD_W-1:0]         prod_s1;
	logic                             vld_s1;
	logic signed [cfvg_pkg::POS_W-1:0] res_s2;
	logic                             vld_s2;
	logic signed [PROD_W-1:0]         sum;
	logic signed [P_W-1:0]            p;

	assign rad_s = $signed({1'b0, radius});
	assign sum   = prod_s1 + (PROD_W'(1) <<< (cfvg_pkg::FRAC_BITS - 1));
	assign p     = P_W'(sum >>> cfvg_pkg::FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= rad_s * value;
		end
		if (vld_s1) begin
			if (p > P_HI) begin
				res_s2 <= cfvg_pkg::POS_W'(P_HI);
			end else if (p < P_LO) begin
				res_s2 <= cfvg_pkg::POS_W'(P_LO);
			end else begin
				res_s2 <= cfvg_pkg::POS_W'(p);
			end
		end
	end

	assign done   = vld_s2;
	assign result = res_s2;

endmodule

FILE: hw/rtl/circle_fan_vertex_gen_top.sv
// Circle triangle-fan vertex generator: sequencer around the divider, CORDIC and scaler.
//
// One transfer on the s_axis channel carries a circle request (radius in unsigned Q8.8,
// segment count). A count of zero is taken as one, and counts above 62 as 62. The block
// then sends count+2 vertices on the m_axis channel: the centre, the count rim points in
// counterclockwise order, and a copy of the first rim point with tlast set.
// While a request is in progress s_axis_tready stays low; it rises again the cycle after
// the closing vertex is transferred.
// The segment count is divided into a full turn once per request, in the bit-serial
// divider, before the centre vertex is presented. Each rim vertex then takes the 24
// iterations of the single CORDIC unit plus two passes through the shared two-stage
// radius multiplier.
// Each vertex sits in the output register until it is transferred; a stall on m_axis_tready
// simply holds the sequencer, nothing is lost. After reset the block is idle and ready.
module circle_fan_vertex_gen_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [cfvg_pkg::IN_W-1:0]       s_axis_tdata,  // radius[15:0], segment_count[21:16]
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [cfvg_pkg::OUT_W-1:0]      m_axis_tdata,  // vertex_index[5:0], pos_x[22:6], pos_y[39:23]
	output logic                            m_axis_tlast
);

	cfvg_pkg::state_t state_q;
	cfvg_pkg::state_t state_nx;

	logic [cfvg_pkg::RAD_W-1:0]        rad_q;
	logic [cfvg_pkg::SEG_W-1:0]        cnt_q;
	logic [cfvg_pkg::SEG_W-1:0]        idx_q;
	logic                              last_q;
	logic [cfvg_pkg::PH_W-1:0]         quo0_q;
	logic [cfvg_pkg::SEG_W-1:0]        rem0_q;
	logic [cfvg_pkg::PH_W-1:0]         ph_q;
	logic [cfvg_pkg::SEG_W-1:0]        r_q;
	logic signed [cfvg_pkg::POS_W-1:0] pos_x_q;
	logic signed [cfvg_pkg::POS_W-1:0] pos_y_q;
	logic signed [cfvg_pkg::POS_W-1:0] fx_q;
	logic signed [cfvg_pkg::POS_W-1:0] fy_q;

	logic [cfvg_pkg::SEG_W-1:0]        seg_in;
	logic [cfvg_pkg::SEG_W-1:0]        cnt_in;
	logic                              s_fire;
	logic                              m_fire;
	logic [cfvg_pkg::SEG_W:0]          r_sum;
	logic                              wrap;
	logic [cfvg_pkg::SEG_W-1:0]        r_nx;
	logic [cfvg_pkg::PH_W-1:0]         ph_nx;
	logic [cfvg_pkg::TURN_W-1:0]       turn;

	logic                              div_done;
	logic [cfvg_pkg::PH_W-1:0]         div_quo;
	logic [cfvg_pkg::SEG_W-1:0]        div_rem;
	logic                              cord_start;
	logic                              cord_done;
	logic signed [cfvg_pkg::V_W-1:0]   cos_v;
	logic signed [cfvg_pkg::V_W-1:0]   sin_v;
	logic                              scl_start;
	logic signed [cfvg_pkg::V_W-1:0]   scl_v;
	logic                              scl_done;
	logic signed [cfvg_pkg::POS_W-1:0] scl_res;

	assign seg_in = s_axis_tdata[cfvg_pkg::RAD_W+cfvg_pkg::SEG_W-1:cfvg_pkg::RAD_W];
	assign cnt_in = (seg_in == '0) ? cfvg_pkg::SEG_W'(1) :
			(seg_in > cfvg_pkg::SEG_W'(cfvg_pkg::MAX_SEGMENTS)) ?
			cfvg_pkg::SEG_W'(cfvg_pkg::MAX_SEGMENTS) : seg_in;

	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_fire = m_axis_tvalid && m_axis_tready;

	// The phase round(i*2^ANGLE_BITS/count) advances by the quotient of a full turn per vertex,
	// with the remainder carried in r_q so that the rounding stays exact.
	assign r_sum = {1'b0, r_q} + {1'b0, rem0_q};
	assign wrap  = r_sum >= {1'b0, cnt_q};
	assign r_nx  = wrap ? cfvg_pkg::SEG_W'(r_sum - {1'b0, cnt_q}) : r_sum[cfvg_pkg::SEG_W-1:0];
	assign ph_nx = ph_q + quo0_q + cfvg_pkg::PH_W'(wrap);
	assign turn  = {ph_nx[cfvg_pkg::ANGLE_BITS-1:0],
			(cfvg_pkg::TURN_W - cfvg_pkg::ANGLE_BITS)'(0)};

	cfvg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_fire),
		.divisor   (cnt_in),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	cfvg_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.turn   (turn),
		.done   (cord_done),
		.cos_v  (cos_v),
		.sin_v  (sin_v)
	);

	cfvg_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scl_start),
		.radius (rad_q),
		.value  (scl_v),
		.done   (scl_done),
		.result (scl_res)
	);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			cfvg_pkg::ST_IDLE: begin
				if (s_fire) state_nx = cfvg_pkg::ST_DIV;
			end
			cfvg_pkg::ST_DIV: begin
				if (div_done) state_nx = cfvg_pkg::ST_OUT;
			end
			cfvg_pkg::ST_OUT: begin
				if (m_fire) begin
					if (last_q) begin
						state_nx = cfvg_pkg::ST_IDLE;
					end else if (idx_q == cnt_q) begin
						state_nx = cfvg_pkg::ST_OUT;
					end else begin
						state_nx = cfvg_pkg::ST_STEP;
					end
				end
			end
			cfvg_pkg::ST_STEP: begin
				state_nx = cfvg_pkg::ST_CORD;
			end
			cfvg_pkg::ST_CORD: begin
				if (cord_done) state_nx = cfvg_pkg::ST_SCL_X;
			end
			cfvg_pkg::ST_SCL_X: begin
				if (scl_done) state_nx = cfvg_pkg::ST_SCL_Y;
			end
			cfvg_pkg::ST_SCL_Y: begin
				if (scl_done) state_nx = cfvg_pkg::ST_OUT;
			end
			default: begin
				state_nx = cfvg_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == cfvg_pkg::ST_IDLE);
		m_axis_tvalid = (state_q == cfvg_pkg::ST_OUT);
		cord_start    = (state_q == cfvg_pkg::ST_STEP);
		scl_start     = ((state_q == cfvg_pkg::ST_CORD) && cord_done) ||
				((state_q == cfvg_pkg::ST_SCL_X) && scl_done);
		scl_v         = (state_q == cfvg_pkg::ST_CORD) ? cos_v : sin_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfvg_pkg::ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (s_fire) begin
				cnt_q  <= cnt_in;
				idx_q  <= '0;
				last_q <= 1'b0;
			end else if (state_q == cfvg_pkg::ST_STEP) begin
				idx_q <= idx_q + 1'b1;
			end else if (m_fire && !last_q && (idx_q == cnt_q)) begin
				idx_q  <= idx_q + 1'b1;
				last_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			rad_q   <= s_axis_tdata[cfvg_pkg::RAD_W-1:0];
			pos_x_q <= '0;
			pos_y_q <= '0;
		end
		if ((state_q == cfvg_pkg::ST_DIV) && div_done) begin
			quo0_q <= div_quo;
			rem0_q <= div_rem;
			ph_q   <= '0;
			r_q    <= cnt_q >> 1;
		end
		if (state_q == cfvg_pkg::ST_STEP) begin
			ph_q <= ph_nx;
			r_q  <= r_nx;
		end
		if (m_fire && !last_q && (idx_q == cnt_q)) begin
			pos_x_q <= fx_q;
			pos_y_q <= fy_q;
		end
		if ((state_q == cfvg_pkg::ST_SCL_X) && scl_done) begin
			pos_x_q <= scl_res;
		end
		if ((state_q == cfvg_pkg::ST_SCL_Y) && scl_done) begin
			pos_y_q <= scl_res;
			if (idx_q == cfvg_pkg::SEG_W'(1)) begin
				fx_q <= pos_x_q;
				fy_q <= scl_res;
			end
		end
	end

	assign m_axis_tdata = {pos_y_q, pos_x_q, idx_q};
	assign m_axis_tlast = last_q;

`ifndef SYNTH
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input accepted while a vertex is pending");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> idx_q == cfvg_pkg::SEG_W'(cnt_q + 1'b1))
		else $error("closing vertex has the wrong index");

	a_cord_owned: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> state_q == cfvg_pkg::ST_CORD)
		else $error("CORDIC finished outside its sequencer state");

	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_fire && m_axis_tlast |=> s_axis_tready)
		else $error("block not idle after the closing vertex");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> idx_q <= cfvg_pkg::SEG_W'(cnt_q + 1'b1))
		else $error("vertex index ran past the fan");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench of the circle fan vertex generator: directed and random circle requests.
module tb;
	import cfvg_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 11;
	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int TAIL_CYCLES  = 200;
	localparam int REPORT_MAX   = 10;
	localparam longint GAIN_Q30 = 652032874;
	localparam longint HALF_LSB = 64'sd536870912;

	typedef struct packed {
		logic [SEG_W-1:0] idx;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic             closing;
	} fan_vertex_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_W-1:0]    m_axis_tdata;
	logic                m_axis_tlast;

	// Rotation angles atan(2^-k) in units of 2^-32 of a turn.
	longint atan_lut [0:CORDIC_STEPS-1] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	fan_vertex_t expected_vertex_q[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	bit          sink_stalls = 1'b0;
	bit          source_gaps = 1'b0;

	circle_fan_vertex_gen_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// Mostly short stalls, now and then a long one.
	function automatic int stall_length();
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic int request_gap();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 0;
		if (r < 9)
			return $urandom_range(1, 4);
		return $urandom_range(20, 600);
	endfunction

	// Cosine and sine in Q2.30 of an angle given in 2^-32 turns.
	function automatic void rotate_turn(input logic [TURN_W-1:0] turn, output longint c,
			output longint s);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		longint t;
		int k;
		x = GAIN_Q30;
		y = 0;
		z = longint'(turn[TURN_W-3:0]);
		for (k = 0; k < CORDIC_STEPS; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - atan_lut[k];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + atan_lut[k];
			end
		end
		// The top two angle bits pick the quadrant.
		case (turn[TURN_W-1:TURN_W-2])
			2'd1: begin
				t = x;
				x = -y;
				y = t;
			end
			2'd2: begin
				x = -x;
				y = -y;
			end
			2'd3: begin
				t = x;
				x = y;
				y = -t;
			end
			default: ;
		endcase
		c = x;
		s = y;
	endfunction

	function automatic logic [POS_W-1:0] scale_coord(input logic [RAD_W-1:0] radius,
			input longint v);
		longint p;
		p = (longint'(radius) * v + HALF_LSB) >>> FRAC_BITS;
		if (p > POS_MAX)
			p = POS_MAX;
		if (p < -POS_MAX)
			p = -POS_MAX;
		return p[POS_W-1:0];
	endfunction

	task automatic queue_fan_vertices(input logic [RAD_W-1:0] radius,
			input logic [SEG_W-1:0] raw_count);
		int unsigned segs;
		int unsigned i;
		int unsigned phase;
		logic [TURN_W-1:0] turn;
		longint c;
		longint s;
		fan_vertex_t v;
		fan_vertex_t first_rim;
		segs = raw_count;
		if (segs == 0)
			segs = 1;
		if (segs > MAX_SEGMENTS)
			segs = MAX_SEGMENTS;
		v = '{idx: '0, x: '0, y: '0, closing: 1'b0};
		expected_vertex_q.push_back(v);
		first_rim = v;
		for (i = 1; i <= segs; i++) begin
			phase = ((i << ANGLE_BITS) + segs / 2) / segs;
			phase = phase & ((1 << ANGLE_BITS) - 1);
			turn = TURN_W'(phase) << (TURN_W - ANGLE_BITS);
			rotate_turn(turn, c, s);
			v.idx = SEG_W'(i);
			v.x = scale_coord(radius, c);
			v.y = scale_coord(radius, s);
			v.closing = 1'b0;
			if (i == 1)
				first_rim = v;
			expected_vertex_q.push_back(v);
		end
		// The fan is closed by repeating the first rim point.
		v = first_rim;
		v.idx = SEG_W'(segs + 1);
		v.closing = 1'b1;
		expected_vertex_q.push_back(v);
	endtask

	task automatic send_circle(input logic [RAD_W-1:0] radius, input logic [SEG_W-1:0] count);
		int gap;
		gap = source_gaps ? request_gap() : 0;
		// Valid was lowered at the previous transfer edge, so never raise it in that step.
		@(posedge clk);
		repeat (gap) @(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_W - RAD_W - SEG_W){1'b0}}, count, radius};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		queue_fan_vertices(radius, count);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_for_fan_done();
		while (expected_vertex_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic note_mismatch(input string what, input int want, input int got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("mismatch in %s: expected %0d, got %0d", what, want, got);
	endtask

	always @(posedge clk) begin
		int stall_left;
		if (!sink_stalls) begin
			m_axis_tready <= 1'b1;
			stall_left = 0;
		end else if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = stall_length();
		end
	end

	always @(posedge clk) begin
		fan_vertex_t want;
		fan_vertex_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.idx = m_axis_tdata[SEG_W-1:0];
			got.x = m_axis_tdata[SEG_W +: POS_W];
			got.y = m_axis_tdata[SEG_W + POS_W +: POS_W];
			got.closing = m_axis_tlast;
			if (expected_vertex_q.size() == 0) begin
				note_mismatch("vertex index, no vertex expected", -1, int'(got.idx));
			end else begin
				want = expected_vertex_q.pop_front();
				if (got.idx != want.idx)
					note_mismatch("vertex index", int'(want.idx), int'(got.idx));
				if (got.x != want.x)
					note_mismatch($sformatf("x of vertex %0d", want.idx),
						int'($signed(want.x)), int'($signed(got.x)));
				if (got.y != want.y)
					note_mismatch($sformatf("y of vertex %0d", want.idx),
						int'($signed(want.y)), int'($signed(got.y)));
				if (got.closing != want.closing)
					note_mismatch($sformatf("tlast of vertex %0d", want.idx),
						int'(want.closing), int'(got.closing));
			end
		end
	end

	// Zero segments, one to three, counts at and above the saturation point, and one mid count.
	task automatic test_segment_count_limits();
		sink_stalls = 1'b1;
		source_gaps = 1'b1;
		send_circle(16'h0100, 6'd0);
		send_circle(16'h0100, 6'd1);
		send_circle(16'h0100, 6'd2);
		send_circle(16'h0100, 6'd3);
		send_circle(16'h0A80, 6'd62);
		send_circle(16'h0A80, 6'd63);
		send_circle(16'h1234, 6'd32);
	endtask

	// Zero radius, the smallest step, the full radius, where coordinates reach the clamp bound, and some in between.
	task automatic test_radius_limits();
		send_circle(16'h0000, 6'd5);
		send_circle(16'h0001, 6'd4);
		send_circle(16'hFFFF, 6'd4);
		send_circle(16'hFFFF, 6'd63);
		send_circle(16'h8000, 6'd8);
		send_circle(16'h7FFF, 6'd6);
		send_circle(16'h00FF, 6'd3);
	endtask

	// Counts that do not divide a turn evenly, so the phase is rounded.
	task automatic test_angle_rounding();
		send_circle(16'h4000, 6'd7);
		send_circle(16'h2000, 6'd11);
		send_circle(16'h3000, 6'd13);
		send_circle(16'hFFFF, 6'd45);
	endtask

	task automatic test_random_small_fans();
		int n;
		sink_stalls = 1'b1;
		source_gaps = 1'b1;
		for (n = 0; n < 54; n++)
			send_circle(16'($urandom), 6'($urandom_range(0, 12)));
	endtask

	task automatic test_random_any_count();
		int n;
		for (n = 0; n < 18; n++)
			send_circle(16'($urandom), 6'($urandom_range(0, 63)));
	endtask

	task automatic test_back_to_back();
		int n;
		sink_stalls = 1'b0;
		source_gaps = 1'b0;
		for (n = 0; n < 10; n++)
			send_circle(16'($urandom), 6'($urandom_range(0, 16)));
	endtask

	task automatic test_pause_until_drained();
		int n;
		sink_stalls = 1'b1;
		source_gaps = 1'b1;
		for (n = 0; n < 10; n++) begin
			wait_for_fan_done();
			send_circle(16'($urandom), 6'($urandom_range(0, 20)));
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_segment_count_limits();
		test_radius_limits();
		test_angle_rounding();
		test_random_small_fans();
		test_random_any_count();
		test_back_to_back();
		test_pause_until_drained();
		wait_for_fan_done();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_vertex_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/cfvg_pkg.sv
hw/rtl/cfvg_div.sv
hw/rtl/cfvg_cordic.sv
hw/rtl/cfvg_scale.sv
hw/rtl/circle_fan_vertex_gen_top.sv
tb/tb.sv
